>>> sv/timed_event_queue_macros.svh
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/teq_pkg.sv
package teq_pkg;

  typedef struct packed {
    logic [31:0]        due_time;
    logic [3:0]         kind;
    logic signed [15:0] arg_first;
    logic signed [15:0] arg_second;
    logic signed [15:0] arg_third;
  } entry_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [31:0]        event_time;
    logic [3:0]         event_type;
    logic signed [15:0] arg_first;
    logic signed [15:0] arg_second;
    logic signed [15:0] arg_third;
    logic [31:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic [3:0]         due_type;
    logic signed [15:0] due_arg_first;
    logic signed [15:0] due_arg_second;
    logic signed [15:0] due_arg_third;
    logic               last;
    logic               status;
    logic               servo_found;
    logic [7:0]         next_note;
    logic [5:0]         note_count;
    logic [31:0]        processed_count;
  } out_item_t;

  // Summary gathered by one pass over the queue.
  typedef struct packed {
    logic [5:0] note_count;
    logic       note_seen;
    logic [7:0] next_note;
    logic       servo_found;
    logic       head_due;
    entry_t     head;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_SCAN,
    S_SRV_DEC,
    S_EMIT
  } state_t;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_SERVICE = 3'd1;
  localparam logic [2:0] MODE_QUERY   = 3'd2;
  localparam logic [2:0] MODE_REPLACE = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  localparam logic [1:0] CFG_NOTE_TYPE  = 2'd0;
  localparam logic [1:0] CFG_SERVO_TYPE = 2'd1;
  localparam logic [1:0] CFG_NO_NOTE    = 2'd2;

  localparam logic [5:0] MAX_RESULTS    = 6'd32;
  localparam logic [5:0] NOTE_COUNT_MAX = 6'd63;

endpackage

>>> sv/teq_ram.sv
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/teq_scan.sv
module teq_scan (
  input  logic                clk,
  input  logic                clear,
  input  logic                en,
  input  logic                first,
  input  teq_pkg::entry_t     ent,
  input  logic [3:0]          note_code,
  input  logic [3:0]          servo_code,
  input  logic [31:0]         now_time,
  input  logic signed [15:0]  board,
  input  logic signed [15:0]  servo,
  output logic                match,
  output teq_pkg::scan_res_t  res
);

  teq_pkg::scan_res_t res_r;
  teq_pkg::scan_res_t res_nxt;
  logic               is_note;

  assign is_note = (ent.kind == note_code);
  assign match   = en && (ent.kind == servo_code) && (ent.arg_first == board) &&
                   (ent.arg_second == servo);

  always_comb begin
    res_nxt = res_r;
    if (clear) begin
      res_nxt = '0;
    end else if (en) begin
      if (is_note) begin
        if (res_r.note_count != teq_pkg::NOTE_COUNT_MAX) begin
          res_nxt.note_count = res_r.note_count + 6'd1;
        end
        if (!res_r.note_seen) begin
          res_nxt.note_seen = 1'b1;
          res_nxt.next_note = ent.arg_first[7:0];
        end
      end
      if (match) begin
        res_nxt.servo_found = 1'b1;
      end
      if (first) begin
        res_nxt.head     = ent;
        res_nxt.head_due = (ent.due_time < now_time);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

>>> sv/timed_event_queue.sv
// Time-ordered event queue. Events live in one synchronous RAM used as a ring
// buffer; a transaction on the input channel is one command. An insert walks
// back from the tail, moving later entries up by one, reading and then writing
// each entry it passes. Every command ends with one pass over the queue that
// counts note events, finds the first note and checks servo entries, since
// these depend on the configured type codes. A service command pops due events
// from the head; each emitted event costs one further pass. Each pass reads the
// RAM one entry per cycle. A new command is accepted only when the previous one
// has delivered all its results into the output register.
`include "timed_event_queue_macros.svh"

module timed_event_queue #(
  parameter int CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  teq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output teq_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  teq_pkg::state_t     state_r, state_nxt;
  teq_pkg::in_item_t   item_r, item_nxt;
  teq_pkg::entry_t     ev_r, ev_nxt;
  teq_pkg::out_item_t  out_r, out_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [OW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [5:0]          n_r, n_nxt;
  logic                have_ev_r, have_ev_nxt;
  logic                drop_r, drop_nxt;
  logic [31:0]         total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          note_code_r, servo_code_r;
  logic [7:0]          no_note_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  teq_pkg::entry_t     ram_wdata, rd_ent;
  logic [$bits(teq_pkg::entry_t)-1:0] ram_rdata;

  logic                scan_clear, scan_en, scan_first, scan_match;
  teq_pkg::scan_res_t  scan_res;

  logic                accept, out_free, is_service, emit_last, ins_place;
  teq_pkg::entry_t     new_ent;

  function automatic logic [AW-1:0] log2phys(input logic [OW-1:0] li,
                                             input logic [AW-1:0] hd);
    logic [AW:0] s;
    s = {1'b0, hd} + (AW+1)'(li);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  teq_ram #(
    .WIDTH($bits(teq_pkg::entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_ent = teq_pkg::entry_t'(ram_rdata);

  teq_scan u_scan (
    .clk       (clk),
    .clear     (scan_clear),
    .en        (scan_en),
    .first     (scan_first),
    .ent       (rd_ent),
    .note_code (note_code_r),
    .servo_code(servo_code_r),
    .now_time  (item_r.now_time),
    .board     (item_r.arg_first),
    .servo     (item_r.arg_second),
    .match     (scan_match),
    .res       (scan_res)
  );

  assign in_stall   = (state_r != teq_pkg::S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign is_service = (item_r.mode == teq_pkg::MODE_SERVICE);
  // More due events follow when the fresh head is due and the budget allows.
  assign emit_last  = !(is_service && have_ev_r && scan_res.head_due &&
                        (n_r < teq_pkg::MAX_RESULTS));
  assign ins_place  = (rd_ent.due_time < item_r.event_time);

  assign new_ent.due_time   = item_r.event_time;
  assign new_ent.kind       = item_r.event_type;
  assign new_ent.arg_first  = item_r.arg_first;
  assign new_ent.arg_second = item_r.arg_second;
  assign new_ent.arg_third  = item_r.arg_third;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      teq_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_data.mode == teq_pkg::MODE_INSERT) && (occ_r != OW'(CAPACITY))) begin
            state_nxt = teq_pkg::S_INS_RD;
          end else begin
            state_nxt = teq_pkg::S_SCAN;
          end
        end
      end
      teq_pkg::S_INS_RD: begin
        state_nxt = (idx_r == '0) ? teq_pkg::S_SCAN : teq_pkg::S_INS_WR;
      end
      teq_pkg::S_INS_WR: begin
        state_nxt = ins_place ? teq_pkg::S_SCAN : teq_pkg::S_INS_RD;
      end
      teq_pkg::S_SCAN: begin
        if (idx_r == occ_r) begin
          state_nxt = (is_service && !have_ev_r) ? teq_pkg::S_SRV_DEC : teq_pkg::S_EMIT;
        end
      end
      teq_pkg::S_SRV_DEC: begin
        state_nxt = scan_res.head_due ? teq_pkg::S_SCAN : teq_pkg::S_EMIT;
      end
      teq_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = emit_last ? teq_pkg::S_IDLE : teq_pkg::S_SCAN;
        end
      end
      default: state_nxt = teq_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    item_nxt      = item_r;
    ev_nxt        = ev_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    n_nxt         = n_r;
    have_ev_nxt   = have_ev_r;
    drop_nxt      = drop_r;
    total_nxt     = total_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = rd_ent;
    ram_raddr     = head_r;
    scan_clear    = 1'b0;
    scan_en       = 1'b0;
    scan_first    = 1'b0;
    case (state_r)
      teq_pkg::S_IDLE: begin
        if (accept) begin
          item_nxt    = in_data;
          n_nxt       = '0;
          have_ev_nxt = 1'b0;
          drop_nxt    = 1'b0;
          idx_nxt     = '0;
          scan_clear  = 1'b1;
          if (in_data.mode == teq_pkg::MODE_INSERT) begin
            if (occ_r == OW'(CAPACITY)) begin
              drop_nxt = 1'b1;
            end else begin
              idx_nxt = occ_r;
            end
          end else if (in_data.mode == teq_pkg::MODE_CLEAR) begin
            occ_nxt = '0;
          end
        end
      end
      teq_pkg::S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = log2phys('0, head_r);
          ram_wdata  = new_ent;
          occ_nxt    = occ_r + OW'(1);
          scan_clear = 1'b1;
        end else begin
          ram_raddr = log2phys(idx_r - OW'(1), head_r);
        end
      end
      teq_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = log2phys(idx_r, head_r);
        if (ins_place) begin
          ram_wdata  = new_ent;
          occ_nxt    = occ_r + OW'(1);
          idx_nxt    = '0;
          scan_clear = 1'b1;
        end else begin
          ram_wdata = rd_ent;
          idx_nxt   = idx_r - OW'(1);
        end
      end
      teq_pkg::S_SCAN: begin
        // Read entry idx while folding in entry idx - 1 from the last read.
        ram_raddr = log2phys(idx_r, head_r);
        if (idx_r != '0) begin
          scan_en    = 1'b1;
          scan_first = (idx_r == OW'(1));
          if (scan_match && (item_r.mode == teq_pkg::MODE_REPLACE)) begin
            ram_we              = 1'b1;
            ram_waddr           = log2phys(idx_r - OW'(1), head_r);
            ram_wdata           = rd_ent;
            ram_wdata.arg_third = item_r.arg_third;
          end
        end
        if (idx_r != occ_r) begin
          idx_nxt = idx_r + OW'(1);
        end
      end
      teq_pkg::S_SRV_DEC: begin
        if (scan_res.head_due) begin
          ev_nxt      = scan_res.head;
          have_ev_nxt = 1'b1;
          head_nxt    = log2phys(OW'(1), head_r);
          occ_nxt     = occ_r - OW'(1);
          total_nxt   = total_r + 32'd1;
          n_nxt       = n_r + 6'd1;
          idx_nxt     = '0;
          scan_clear  = 1'b1;
        end
      end
      teq_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.event_valid     = have_ev_r;
          out_nxt.due_type        = have_ev_r ? ev_r.kind : 4'd0;
          out_nxt.due_arg_first   = have_ev_r ? ev_r.arg_first : 16'sd0;
          out_nxt.due_arg_second  = have_ev_r ? ev_r.arg_second : 16'sd0;
          out_nxt.due_arg_third   = have_ev_r ? ev_r.arg_third : 16'sd0;
          out_nxt.last            = emit_last;
          out_nxt.status          = drop_r;
          out_nxt.servo_found     = scan_res.servo_found &&
                                    ((item_r.mode == teq_pkg::MODE_QUERY) ||
                                     (item_r.mode == teq_pkg::MODE_REPLACE));
          out_nxt.next_note       = scan_res.note_seen ? scan_res.next_note : no_note_r;
          out_nxt.note_count      = scan_res.note_count;
          out_nxt.processed_count = total_r;
          if (!emit_last) begin
            // The head just scanned is due: pop it for the next result.
            ev_nxt     = scan_res.head;
            head_nxt   = log2phys(OW'(1), head_r);
            occ_nxt    = occ_r - OW'(1);
            total_nxt  = total_r + 32'd1;
            n_nxt      = n_r + 6'd1;
            idx_nxt    = '0;
            scan_clear = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= teq_pkg::S_IDLE;
      occ_r        <= '0;
      head_r       <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      have_ev_r    <= 1'b0;
      n_r          <= '0;
      drop_r       <= 1'b0;
      idx_r        <= '0;
      note_code_r  <= 4'd1;
      servo_code_r <= 4'd0;
      no_note_r    <= 8'd255;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      have_ev_r   <= have_ev_nxt;
      n_r         <= n_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          teq_pkg::CFG_NOTE_TYPE:  note_code_r  <= cfg_data[3:0];
          teq_pkg::CFG_SERVO_TYPE: servo_code_r <= cfg_data[3:0];
          teq_pkg::CFG_NO_NOTE:    no_note_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ev_r   <= ev_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TEQ_ASSERT(a_occ_bound, occ_r <= OW'(CAPACITY), "occupancy above capacity")
  `TEQ_ASSERT(a_head_bound, (AW+1)'(head_r) < (AW+1)'(CAPACITY), "head pointer out of range")
  `TEQ_ASSERT_NEXT(a_last_idle, (state_r == teq_pkg::S_EMIT) && out_free && emit_last, (state_r == teq_pkg::S_IDLE) && out_valid_r && out_r.last, "final result did not end the command")

endmodule

>>> tb/sv/tb_timed_event_queue.sv
`timescale 1ns / 1ps

// Self-checking bench for the time-ordered event queue. A behavioral model of
// the queue predicts every result of each accepted command transaction; a
// separate process compares the results the block delivers, in order, field
// by field against that prediction.
module tb_timed_event_queue;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  teq_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  teq_pkg::out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  timed_event_queue #(.CAPACITY(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state: the queue contents and the configured type codes.
  teq_pkg::entry_t q_entry[DEPTH];
  int         q_fill;
  logic [31:0] q_emitted;
  logic [3:0] note_code;
  logic [3:0] servo_code;
  logic [7:0] no_note;

  teq_pkg::out_item_t pending_results[$];
  int         error_count;
  int         cycle_count;
  bit         idle_enabled;
  bit         hold_receiver;
  int         hold_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Fills in next_note, note_count and processed_count from the current model state.
  function automatic teq_pkg::out_item_t with_note_summary(teq_pkg::out_item_t r);
    int n;
    bit seen;
    n = 0;
    seen = 0;
    r.next_note = no_note;
    for (int i = 0; i < q_fill; i++) begin
      if (q_entry[i].kind == note_code) begin
        if (!seen) begin
          r.next_note = q_entry[i].arg_first[7:0];
        end
        seen = 1;
        n++;
      end
    end
    r.note_count = (n > 63) ? 6'd63 : 6'(n);
    r.processed_count = q_emitted;
    return r;
  endfunction

  // Applies one command to the model and queues the results it causes.
  task automatic predict_command(input teq_pkg::in_item_t c);
    teq_pkg::out_item_t r;
    int pos;
    int emitted;
    bit found;
    emitted = 0;
    found = 0;
    r = '0;
    case (c.mode)
      teq_pkg::MODE_INSERT: begin
        if (q_fill >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          pos = 0;
          while (pos < q_fill && q_entry[pos].due_time < c.event_time) pos++;
          for (int i = q_fill; i > pos; i--) q_entry[i] = q_entry[i - 1];
          q_entry[pos] = '{c.event_time, c.event_type, c.arg_first, c.arg_second,
                           c.arg_third};
          q_fill++;
        end
        r.last = 1'b1;
        pending_results.push_back(with_note_summary(r));
      end
      teq_pkg::MODE_SERVICE: begin
        // Due events leave from the head, at most a fixed number per command.
        while (q_fill > 0 && emitted < 32 && q_entry[0].due_time < c.now_time) begin
          r = '0;
          r.event_valid = 1'b1;
          r.due_type = q_entry[0].kind;
          r.due_arg_first = q_entry[0].arg_first;
          r.due_arg_second = q_entry[0].arg_second;
          r.due_arg_third = q_entry[0].arg_third;
          for (int i = 1; i < q_fill; i++) q_entry[i - 1] = q_entry[i];
          q_fill--;
          q_emitted++;
          emitted++;
          pending_results.push_back(with_note_summary(r));
        end
        if (emitted == 0) begin
          pending_results.push_back(with_note_summary('0));
        end
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      teq_pkg::MODE_QUERY, teq_pkg::MODE_REPLACE: begin
        for (int i = 0; i < q_fill; i++) begin
          if (q_entry[i].kind == servo_code && q_entry[i].arg_first == c.arg_first &&
              q_entry[i].arg_second == c.arg_second) begin
            found = 1;
            if (c.mode == teq_pkg::MODE_REPLACE) q_entry[i].arg_third = c.arg_third;
          end
        end
        r.servo_found = found;
        r.last = 1'b1;
        pending_results.push_back(with_note_summary(r));
      end
      default: begin
        // Clear empties the queue; unknown modes only report the state.
        if (c.mode == teq_pkg::MODE_CLEAR) q_fill = 0;
        r.last = 1'b1;
        pending_results.push_back(with_note_summary(r));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Result checker: every accepted result is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    teq_pkg::out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data.event_valid), 0);
      end else begin
        w = pending_results.pop_front();
        if (out_data.event_valid !== w.event_valid)
          report_mismatch("event_valid", 32'(out_data.event_valid), 32'(w.event_valid));
        if (out_data.due_type !== w.due_type)
          report_mismatch("due_type", 32'(out_data.due_type), 32'(w.due_type));
        if (out_data.due_arg_first !== w.due_arg_first)
          report_mismatch("due_arg_first", 32'(out_data.due_arg_first),
                          32'(w.due_arg_first));
        if (out_data.due_arg_second !== w.due_arg_second)
          report_mismatch("due_arg_second", 32'(out_data.due_arg_second),
                          32'(w.due_arg_second));
        if (out_data.due_arg_third !== w.due_arg_third)
          report_mismatch("due_arg_third", 32'(out_data.due_arg_third),
                          32'(w.due_arg_third));
        if (out_data.last !== w.last)
          report_mismatch("last", 32'(out_data.last), 32'(w.last));
        if (out_data.status !== w.status)
          report_mismatch("status", 32'(out_data.status), 32'(w.status));
        if (out_data.servo_found !== w.servo_found)
          report_mismatch("servo_found", 32'(out_data.servo_found), 32'(w.servo_found));
        if (out_data.next_note !== w.next_note)
          report_mismatch("next_note", 32'(out_data.next_note), 32'(w.next_note));
        if (out_data.note_count !== w.note_count)
          report_mismatch("note_count", 32'(out_data.note_count), 32'(w.note_count));
        if (out_data.processed_count !== w.processed_count)
          report_mismatch("processed_count", out_data.processed_count,
                          w.processed_count);
      end
    end
  end

  // Receiver back-pressure: random stall bursts, or one long hold-off that is
  // counted down here so the block fills up and pushes back on its input.
  always @(posedge clk) begin
    int burst;
    if (!rst_n) begin
      out_stall <= 1'b0;
      burst = 0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
      if (hold_cycles > 0) hold_cycles--;
      else hold_receiver = 0;
    end else if (burst > 0) begin
      burst--;
      out_stall <= (burst != 0);
    end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one command and holds it until the block accepts it; the model is
  // updated at the accepting edge. Valid stays high into the next command
  // unless an idle gap drops it.
  task automatic send_command(input teq_pkg::in_item_t c);
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    predict_command(c);
  endtask

  // Waits until every predicted result has come, plus slack for trailing work.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      teq_pkg::CFG_NOTE_TYPE: note_code = value[3:0];
      teq_pkg::CFG_SERVO_TYPE: servo_code = value[3:0];
      default: no_note = value;
    endcase
  endtask

  function automatic teq_pkg::in_item_t make_command(input logic [2:0] mode,
                                                     input logic [31:0] t,
                                                     input logic [3:0] kind,
                                                     input logic [15:0] a0,
                                                     input logic [15:0] a1,
                                                     input logic [15:0] a2,
                                                     input logic [31:0] now_t);
    teq_pkg::in_item_t c;
    c = '{mode, t, kind, a0, a1, a2, now_t};
    return c;
  endfunction

  // A random command biased toward the useful modes, with times from a narrow
  // window so that service commands actually find due events.
  function automatic teq_pkg::in_item_t random_command();
    int pick;
    logic [2:0] mode;
    logic [31:0] t;
    logic [15:0] a0;
    logic [15:0] a1;
    pick = $urandom_range(0, 99);
    if (pick < 50) mode = teq_pkg::MODE_INSERT;
    else if (pick < 70) mode = teq_pkg::MODE_SERVICE;
    else if (pick < 80) mode = teq_pkg::MODE_QUERY;
    else if (pick < 90) mode = teq_pkg::MODE_REPLACE;
    else if (pick < 94) mode = teq_pkg::MODE_CLEAR;
    else mode = 3'($urandom_range(5, 7));
    t = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 400));
    a0 = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
    a1 = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
    return make_command(mode, t, 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                              : $urandom_range(0, 2)),
                        a0, a1, 16'($urandom()),
                        ($urandom_range(0, 9) == 0) ? $urandom()
                                                    : 32'($urandom_range(0, 450)));
  endfunction

  // Corner cases under the reset configuration: extreme times and arguments,
  // every mode, an empty service, a full queue with a dropped insert and a
  // service that drains the full queue up to the per-command limit.
  task automatic test_directed();
    send_command(make_command(teq_pkg::MODE_SERVICE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_command(make_command(teq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 4'hF, 16'h7FFF,
                              16'h8000, 16'hFFFF, 0));
    send_command(make_command(teq_pkg::MODE_INSERT, 0, 1, 16'h8000, 16'h7FFF, 16'h0000,
                              0));
    send_command(make_command(teq_pkg::MODE_INSERT, 0, 0, 16'd3, 16'd4, 16'd5, 0));
    send_command(make_command(teq_pkg::MODE_QUERY, 0, 0, 16'd3, 16'd4, 0, 0));
    send_command(make_command(teq_pkg::MODE_REPLACE, 0, 0, 16'd3, 16'd4, 16'h8001, 0));
    send_command(make_command(teq_pkg::MODE_QUERY, 0, 0, 16'd3, 16'd5, 0, 0));
    send_command(make_command(teq_pkg::MODE_SERVICE, 0, 0, 0, 0, 0, 0));
    send_command(make_command(3'd5, 0, 0, 0, 0, 0, 0));
    send_command(make_command(3'd7, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              32'hFFFF_FFFF));
    send_command(make_command(teq_pkg::MODE_SERVICE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_command(make_command(teq_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    // Fill to capacity with equal times, then one more insert that is dropped.
    for (int i = 0; i <= DEPTH; i++) begin
      send_command(make_command(teq_pkg::MODE_INSERT, 32'd10, 1, 16'(i), 0, 0, 0));
    end
    send_command(make_command(teq_pkg::MODE_SERVICE, 0, 0, 0, 0, 0, 32'd11));
    drain_results();
  endtask

  // The receiver stalls for a long time while commands keep coming.
  task automatic test_backpressure();
    hold_cycles = 2000;
    hold_receiver = 1;
    for (int i = 0; i < 40; i++) send_command(random_command());
    drain_results();
  endtask

  // Random traffic under several register settings, extremes included.
  task automatic test_random_traffic();
    logic [7:0] settings[4][3];
    settings = '{'{8'd1, 8'd0, 8'd255}, '{8'd0, 8'd15, 8'd0},
                 '{8'd15, 8'd2, 8'd128}, '{8'd2, 8'd1, 8'd77}};
    for (int s = 0; s < 4; s++) begin
      write_register(teq_pkg::CFG_NOTE_TYPE, settings[s][0]);
      write_register(teq_pkg::CFG_SERVO_TYPE, settings[s][1]);
      write_register(teq_pkg::CFG_NO_NOTE, settings[s][2]);
      cfg_we <= 1'b0;
      if (s == 3) idle_enabled = 0;
      for (int i = 0; i < 90; i++) send_command(random_command());
      drain_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    q_fill = 0;
    q_emitted = '0;
    note_code = 4'd1;
    servo_code = 4'd0;
    no_note = 8'd255;
    error_count = 0;
    cycle_count = 0;
    idle_enabled = 1;
    hold_receiver = 0;
    hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_traffic();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/teq_pkg.sv
sv/teq_ram.sv
sv/teq_scan.sv
sv/timed_event_queue.sv
tb/sv/tb_timed_event_queue.sv
